>>> src/pta_pkg.sv
// Shared types and constants of the perspective texel address core.
`default_nettype none
package pta_pkg;

    localparam int CRD_W  = 17;
    localparam int CLIP_W = 32;
    localparam int CFG_W  = 13;
    localparam int BPT_W  = 3;
    localparam int IDX_W  = 2;
    localparam int TXL_W  = 12;
    localparam int OFS_W  = 26;

    localparam logic [IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_BPT        = 2'd2;

    localparam logic [CFG_W-1:0] RST_TEX_WIDTH  = 13'd256;
    localparam logic [CFG_W-1:0] RST_TEX_HEIGHT = 13'd256;
    localparam logic [BPT_W-1:0] RST_BPT        = 3'd3;
    localparam logic [BPT_W-1:0] BPT_FOUR       = 3'd4;

    typedef struct packed {
        logic [CRD_W-1:0]  weight_a;
        logic [CRD_W-1:0]  weight_b;
        logic [CRD_W-1:0]  weight_c;
        logic [CRD_W-1:0]  a_tex_s;
        logic [CRD_W-1:0]  a_tex_t;
        logic [CRD_W-1:0]  b_tex_s;
        logic [CRD_W-1:0]  b_tex_t;
        logic [CRD_W-1:0]  c_tex_s;
        logic [CRD_W-1:0]  c_tex_t;
        logic [CLIP_W-1:0] a_clip_w;
        logic [CLIP_W-1:0] b_clip_w;
        logic [CLIP_W-1:0] c_clip_w;
    } t_pta_in;

    typedef struct packed {
        logic [TXL_W-1:0] texel_x;
        logic [TXL_W-1:0] texel_y;
        logic [OFS_W-1:0] byte_offset;
        logic             degenerate;
    } t_pta_out;

endpackage
`default_nettype wire

>>> src/pta_if.sv
// Channel interfaces for input words, result words and configuration writes.
`default_nettype none
interface pta_in_if;
    logic               valid;
    logic               ready;
    pta_pkg::t_pta_in   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pta_out_if;
    logic               valid;
    logic               ready;
    pta_pkg::t_pta_out  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pta_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [pta_pkg::IDX_W-1:0]    idx;
    logic [pta_pkg::CFG_W-1:0]    data;
    modport source (output valid, output idx, output data, input ready);
    modport sink (input valid, input idx, input data, output ready);
endinterface
`default_nettype wire

>>> src/pta_divider.sv
// Pipelined restoring divider that resolves one quotient bit per stage.
`default_nettype none
module pta_divider #(
    parameter int VW = 32,
    parameter int QW = 48
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [VW-1:0] i_rem,
    input  wire logic [QW-1:0] i_low,
    input  wire logic [VW-1:0] i_div,
    output logic      [QW-1:0] o_quo
);

    logic [VW-1:0] r_rem [QW-1];
    logic [VW-1:0] r_div [QW-1];
    logic [QW-1:0] r_low [QW];

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic [VW-1:0] w_rem;
        logic [VW-1:0] w_div;
        logic [QW-1:0] w_low;
        logic [VW:0]   w_t;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign w_rem = i_rem;
            assign w_div = i_div;
            assign w_low = i_low;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_div = r_div[k-1];
            assign w_low = r_low[k-1];
        end

        assign w_t  = {w_rem, w_low[QW-1]};
        assign w_ge = w_t >= {1'b0, w_div};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_low[k] <= {w_low[QW-2:0], w_ge};
            end
        end

        if (k < QW - 1) begin : g_carry
            logic [VW:0] w_diff;
            assign w_diff = w_t - {1'b0, w_div};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[VW-1:0] : w_t[VW-1:0];
                    r_div[k] <= w_div;
                end
            end
        end
    end

    assign o_quo = r_low[QW-1];

endmodule
`default_nettype wire

>>> src/perspective_texel_address_core.sv
// Top level of the perspective-correct texel address core.
// The texel coordinate width is D = ceil(log2(MAX_TEX_DIM + 1)) bits, and the
// pipelined dividers resolve one quotient bit per stage. One word enters per
// cycle while the output buffer has room or the receiver is ready.
// A two-entry output buffer lets input continue while a result waits.
// Reset clears all valid bits and the output buffer and loads 256, 256 and 3.
`default_nettype none
module perspective_texel_address_core #(
    parameter int MAX_TEX_DIM = 4096
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pta_cfg_if.sink    i_cfg,
    pta_in_if.sink     i_in,
    pta_out_if.source  o_out
);

    localparam int CW     = pta_pkg::CRD_W;
    localparam int KW     = pta_pkg::CLIP_W;
    localparam int DIM_W  = $clog2(MAX_TEX_DIM + 1);
    localparam int PX_W   = CW + DIM_W;
    localparam int XS_W   = PX_W + 1;
    localparam int PY_W   = CW + 2 + DIM_W;
    localparam int MAG_W  = PX_W;
    localparam int NUM_W  = MAG_W + CW;
    localparam int TERM_W = NUM_W + 1;
    localparam int SUM_W  = NUM_W + 3;
    localparam int DT_W   = CW + 17;
    localparam int DEN_W  = DT_W + 2;
    localparam int HI_W   = SUM_W - 1 - DIM_W;
    localparam int LIN_W  = 2 * DIM_W + 1;
    localparam int LAT    = NUM_W + DIM_W + 9;
    localparam int OW     = pta_pkg::OFS_W;

    logic [pta_pkg::CFG_W-1:0] r_tex_width;
    logic [pta_pkg::CFG_W-1:0] r_tex_height;
    logic [pta_pkg::BPT_W-1:0] r_bpt;
    logic [DIM_W-1:0]          w_dim_w;
    logic [DIM_W-1:0]          w_dim_h;

    logic             w_en;
    logic             w_acc;
    logic [LAT-1:0]   r_vld;

    logic [CW-1:0]    w_wt [3];
    logic [CW-1:0]    w_s  [3];
    logic [CW-1:0]    w_t  [3];
    logic [KW-1:0]    w_cw [3];

    logic [CW-1:0]    r1_wt [3];
    logic [CW-1:0]    r1_s  [3];
    logic [CW-1:0]    r1_t  [3];
    logic [KW-1:0]    r1_cw [3];

    logic signed [CW:0] w_tt [3];
    logic [PX_W-1:0]  r2_px [3];
    logic [PY_W-1:0]  r2_py [3];
    logic [CW-1:0]    r2_wt [3];
    logic [KW-1:0]    r2_cw [3];

    logic [XS_W-1:0]  w_xs [3];
    logic [PY_W-1:0]  w_ys [3];
    logic [MAG_W-1:0] r3_mx [3];
    logic [MAG_W-1:0] r3_my [3];
    logic [5:0]       r3_sgn;
    logic [CW-1:0]    r3_wt [3];
    logic [KW-1:0]    r3_cw [3];

    logic [NUM_W-1:0] r4_nx [3];
    logic [NUM_W-1:0] r4_ny [3];
    logic [NUM_W-1:0] r4_nd [3];
    logic [KW-1:0]    r4_cw [3];
    logic [5:0]       r4_sgn;

    logic [NUM_W-1:0] w_qx [3];
    logic [NUM_W-1:0] w_qy [3];
    logic [NUM_W-1:0] w_qd [3];
    logic [5:0]       r_sgn [NUM_W];

    logic signed [TERM_W-1:0] r5_tx [3];
    logic signed [TERM_W-1:0] r5_ty [3];
    logic [DT_W-1:0]          r5_td [3];

    logic signed [SUM_W-1:0] r6_nx;
    logic signed [SUM_W-1:0] r6_ny;
    logic [DEN_W-1:0]        r6_den;

    logic [SUM_W-2:0] w_magx;
    logic [SUM_W-2:0] w_magy;
    logic [HI_W-1:0]  w_hix;
    logic [HI_W-1:0]  w_hiy;
    logic             w_ovx;
    logic             w_ovy;
    logic             w_zx;
    logic             w_zy;
    logic             w_deg;
    logic [DEN_W-1:0] w_remx;
    logic [DEN_W-1:0] w_remy;
    logic [DIM_W-1:0] w_fqx;
    logic [DIM_W-1:0] w_fqy;
    logic [4:0]       r_flg [DIM_W];

    logic [DIM_W-1:0]   w_wm1;
    logic [DIM_W-1:0]   w_hm1;
    logic [DIM_W-1:0]   r8_x;
    logic [DIM_W-1:0]   r8_y;
    logic               r8_deg;
    logic [2*DIM_W-1:0] r9_yw;
    logic [DIM_W-1:0]   r9_x;
    logic [DIM_W-1:0]   r9_y;
    logic               r9_deg;
    logic [LIN_W-1:0]   r10_lin;
    logic [DIM_W-1:0]   r10_x;
    logic [DIM_W-1:0]   r10_y;
    logic               r10_deg;

    logic [OW-1:0]      w_l26;
    pta_pkg::t_pta_out  w_push_data;
    logic               w_push;
    logic               w_pop;
    logic [1:0]         r_cnt;
    pta_pkg::t_pta_out  r_q0;
    pta_pkg::t_pta_out  r_q1;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= pta_pkg::RST_TEX_WIDTH;
            r_tex_height <= pta_pkg::RST_TEX_HEIGHT;
            r_bpt        <= pta_pkg::RST_BPT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.idx)
                pta_pkg::CFG_TEX_WIDTH:  r_tex_width  <= i_cfg.data;
                pta_pkg::CFG_TEX_HEIGHT: r_tex_height <= i_cfg.data;
                pta_pkg::CFG_BPT:        r_bpt        <= i_cfg.data[pta_pkg::BPT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_tex_width == '0) begin
            w_dim_w = DIM_W'(1);
        end else if (32'(r_tex_width) > 32'(MAX_TEX_DIM)) begin
            w_dim_w = DIM_W'(MAX_TEX_DIM);
        end else begin
            w_dim_w = DIM_W'(r_tex_width);
        end
        if (r_tex_height == '0) begin
            w_dim_h = DIM_W'(1);
        end else if (32'(r_tex_height) > 32'(MAX_TEX_DIM)) begin
            w_dim_h = DIM_W'(MAX_TEX_DIM);
        end else begin
            w_dim_h = DIM_W'(r_tex_height);
        end
    end

    // Pipeline control: everything advances together while the buffer has room or the receiver is ready.
    assign w_en       = (r_cnt != 2'd2) || o_out.ready;
    assign i_in.ready = w_en;
    assign w_acc      = i_in.valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_acc};
        end
    end

    assign w_wt[0] = i_in.data.weight_a;
    assign w_wt[1] = i_in.data.weight_b;
    assign w_wt[2] = i_in.data.weight_c;
    assign w_s[0]  = i_in.data.a_tex_s;
    assign w_s[1]  = i_in.data.b_tex_s;
    assign w_s[2]  = i_in.data.c_tex_s;
    assign w_t[0]  = i_in.data.a_tex_t;
    assign w_t[1]  = i_in.data.b_tex_t;
    assign w_t[2]  = i_in.data.c_tex_t;
    assign w_cw[0] = i_in.data.a_clip_w;
    assign w_cw[1] = i_in.data.b_clip_w;
    assign w_cw[2] = i_in.data.c_clip_w;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_tt[i] = $signed((CW + 1)'(65536)) - $signed({1'b0, r1_t[i]});
            w_xs[i] = {1'b0, r2_px[i]} - XS_W'(32768);
            w_ys[i] = r2_py[i] - PY_W'(32768);
        end
    end

    // Corner mapping into texel space and the per-corner products.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_wt[i] <= w_wt[i];
                r1_s[i]  <= w_s[i];
                r1_t[i]  <= w_t[i];
                r1_cw[i] <= (w_cw[i] == '0) ? KW'(1) : w_cw[i];

                r2_px[i] <= PX_W'(r1_s[i]) * PX_W'(w_dim_w);
                r2_py[i] <= PY_W'($signed(PY_W'(w_tt[i])) *
                                  $signed(PY_W'({1'b0, w_dim_h})));
                r2_wt[i] <= r1_wt[i];
                r2_cw[i] <= r1_cw[i];

                r3_mx[i]       <= w_xs[i][XS_W-1] ? MAG_W'(~w_xs[i] + 1'b1)
                                                  : MAG_W'(w_xs[i]);
                r3_my[i]       <= w_ys[i][PY_W-1] ? MAG_W'(~w_ys[i] + 1'b1)
                                                  : MAG_W'(w_ys[i]);
                r3_sgn[2*i]    <= w_xs[i][XS_W-1];
                r3_sgn[2*i+1]  <= w_ys[i][PY_W-1];
                r3_wt[i]       <= r2_wt[i];
                r3_cw[i]       <= r2_cw[i];

                r4_nx[i] <= NUM_W'(r3_mx[i]) * NUM_W'(r3_wt[i]);
                r4_ny[i] <= NUM_W'(r3_my[i]) * NUM_W'(r3_wt[i]);
                r4_nd[i] <= NUM_W'({r3_wt[i], 16'h0000});
                r4_cw[i] <= r3_cw[i];
            end
            r4_sgn <= r3_sgn;
        end
    end

    // Division of every term by the corner's clip w.
    for (genvar c = 0; c < 3; c++) begin : g_corner
        pta_divider #(.VW(KW), .QW(NUM_W)) u_div_x (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem ('0),
            .i_low (r4_nx[c]),
            .i_div (r4_cw[c]),
            .o_quo (w_qx[c])
        );
        pta_divider #(.VW(KW), .QW(NUM_W)) u_div_y (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem ('0),
            .i_low (r4_ny[c]),
            .i_div (r4_cw[c]),
            .o_quo (w_qy[c])
        );
        pta_divider #(.VW(KW), .QW(NUM_W)) u_div_d (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem ('0),
            .i_low (r4_nd[c]),
            .i_div (r4_cw[c]),
            .o_quo (w_qd[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sgn[0] <= r4_sgn;
            for (int k = 1; k < NUM_W; k++) begin
                r_sgn[k] <= r_sgn[k-1];
            end
        end
    end

    // Signed terms, then the three-corner sums.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_tx[i] <= r_sgn[NUM_W-1][2*i]   ? -$signed(TERM_W'(w_qx[i]))
                                                 : $signed(TERM_W'(w_qx[i]));
                r5_ty[i] <= r_sgn[NUM_W-1][2*i+1] ? -$signed(TERM_W'(w_qy[i]))
                                                 : $signed(TERM_W'(w_qy[i]));
                r5_td[i] <= w_qd[i][DT_W-1:0];
            end
            r6_nx  <= SUM_W'(r5_tx[0]) + SUM_W'(r5_tx[1]) + SUM_W'(r5_tx[2]);
            r6_ny  <= SUM_W'(r5_ty[0]) + SUM_W'(r5_ty[1]) + SUM_W'(r5_ty[2]);
            r6_den <= DEN_W'(r5_td[0]) + DEN_W'(r5_td[1]) + DEN_W'(r5_td[2]);
        end
    end

    // Final division: the quotient is known to fit D bits unless it saturates.
    always_comb begin
        w_deg  = (r6_den == '0);
        w_zx   = r6_nx[SUM_W-1] || (r6_nx == '0);
        w_zy   = r6_ny[SUM_W-1] || (r6_ny == '0);
        w_magx = r6_nx[SUM_W-2:0];
        w_magy = r6_ny[SUM_W-2:0];
        w_hix  = HI_W'(w_magx >> DIM_W);
        w_hiy  = HI_W'(w_magy >> DIM_W);
        w_ovx  = w_hix >= HI_W'(r6_den);
        w_ovy  = w_hiy >= HI_W'(r6_den);
        w_remx = w_ovx ? '0 : DEN_W'(w_hix);
        w_remy = w_ovy ? '0 : DEN_W'(w_hiy);
    end

    pta_divider #(.VW(DEN_W), .QW(DIM_W)) u_fdiv_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (w_remx),
        .i_low (w_magx[DIM_W-1:0]),
        .i_div (r6_den),
        .o_quo (w_fqx)
    );

    pta_divider #(.VW(DEN_W), .QW(DIM_W)) u_fdiv_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (w_remy),
        .i_low (w_magy[DIM_W-1:0]),
        .i_div (r6_den),
        .o_quo (w_fqy)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flg[0] <= {w_deg, w_zx, w_ovx, w_zy, w_ovy};
            for (int k = 1; k < DIM_W; k++) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    // Clamp, then the linear address.
    assign w_wm1 = w_dim_w - 1'b1;
    assign w_hm1 = w_dim_h - 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_flg[DIM_W-1][4] || r_flg[DIM_W-1][3]) begin
                r8_x <= '0;
            end else if (r_flg[DIM_W-1][2] || (w_fqx > w_wm1)) begin
                r8_x <= w_wm1;
            end else begin
                r8_x <= w_fqx;
            end
            if (r_flg[DIM_W-1][4] || r_flg[DIM_W-1][1]) begin
                r8_y <= '0;
            end else if (r_flg[DIM_W-1][0] || (w_fqy > w_hm1)) begin
                r8_y <= w_hm1;
            end else begin
                r8_y <= w_fqy;
            end
            r8_deg <= r_flg[DIM_W-1][4];

            r9_yw  <= (2 * DIM_W)'(r8_y) * (2 * DIM_W)'(w_dim_w);
            r9_x   <= r8_x;
            r9_y   <= r8_y;
            r9_deg <= r8_deg;

            r10_lin <= LIN_W'(r9_yw) + LIN_W'(r9_x);
            r10_x   <= r9_x;
            r10_y   <= r9_y;
            r10_deg <= r9_deg;
        end
    end

    assign w_l26 = OW'(r10_lin);

    always_comb begin
        w_push_data.texel_x     = pta_pkg::TXL_W'(r10_x);
        w_push_data.texel_y     = pta_pkg::TXL_W'(r10_y);
        w_push_data.byte_offset = (r_bpt >= pta_pkg::BPT_FOUR) ? (w_l26 << 2)
                                                             : ((w_l26 << 1) + w_l26);
        w_push_data.degenerate  = r10_deg;
    end

    // Two-entry output buffer.
    assign w_push = r_vld[LAT-1] && w_en;
    assign w_pop  = (r_cnt != 2'd0) && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && w_push) begin
            if (r_cnt == 2'd1) begin
                r_q0 <= w_push_data;
            end else begin
                r_q0 <= r_q1;
                r_q1 <= w_push_data;
            end
        end else if (w_pop) begin
            r_q0 <= r_q1;
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_push_data;
            end else begin
                r_q1 <= w_push_data;
            end
        end
    end

    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.data  = r_q0;

endmodule
`default_nettype wire

>>> test/perspective_texel_address_core_test.sv
// Self-checking testbench of the perspective texel address core with a built-in address predictor.
`default_nettype none
module perspective_texel_address_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_MAX   = 4096;
    localparam int LATENCY   = 70;
    localparam int STALL_MAX = 200000;
    localparam int N_RANDOM  = 1430;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        pta_pkg::t_pta_in  word;
        bit                has_known;
        pta_pkg::t_pta_out known;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pta_cfg_if cfg_ch ();
    pta_in_if  pix_ch ();
    pta_out_if adr_ch ();

    perspective_texel_address_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (pix_ch),
        .o_out   (adr_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [pta_pkg::CFG_W-1:0] width_reg;
    logic [pta_pkg::CFG_W-1:0] height_reg;
    logic [pta_pkg::BPT_W-1:0] bpt_reg;

    pta_pkg::t_pta_out texel_queue[$];
    int       mismatches = 0;
    int       stall_cycles = 0;
    int       rx_idle = 0;
    bit       quiet_phase = 1'b0;
    bit       hold_off = 1'b0;
    t_row     rows[$];

    function automatic longint clamp_dim(logic [pta_pkg::CFG_W-1:0] d);
        if (d == 0) return 1;
        if (d > DIM_MAX) return DIM_MAX;
        return d;
    endfunction

    function automatic longint weighted_term(longint c, longint wt, longint w);
        longint mag;
        mag = (c < 0) ? -c : c;
        mag = (mag * wt) / w;
        return (c < 0) ? -mag : mag;
    endfunction

    function automatic longint texel_index(longint num, longint den, longint dim);
        longint q;
        if (num <= 0) return 0;
        q = num / den;
        return (q > dim - 1) ? dim - 1 : q;
    endfunction

    function automatic pta_pkg::t_pta_out predict_texel(pta_pkg::t_pta_in p);
        pta_pkg::t_pta_out r;
        longint wd, ht, bpt, numx, numy, den, x, y, cx, cy;
        longint wt[3], s[3], t[3], cw[3];
        wd = clamp_dim(width_reg);
        ht = clamp_dim(height_reg);
        bpt = (bpt_reg < 3) ? 3 : (bpt_reg > 4) ? 4 : bpt_reg;
        wt = '{p.weight_a, p.weight_b, p.weight_c};
        s  = '{p.a_tex_s, p.b_tex_s, p.c_tex_s};
        t  = '{p.a_tex_t, p.b_tex_t, p.c_tex_t};
        cw = '{p.a_clip_w, p.b_clip_w, p.c_clip_w};
        numx = 0;
        numy = 0;
        den = 0;
        for (int i = 0; i < 3; i++) begin
            if (cw[i] == 0) cw[i] = 1;
            cx = s[i] * wd - 32768;
            cy = (65536 - t[i]) * ht - 32768;
            numx += weighted_term(cx, wt[i], cw[i]);
            numy += weighted_term(cy, wt[i], cw[i]);
            den += (wt[i] << 16) / cw[i];
        end
        r = '0;
        if (den == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        x = texel_index(numx, den, wd);
        y = texel_index(numy, den, ht);
        r.texel_x = x[pta_pkg::TXL_W-1:0];
        r.texel_y = y[pta_pkg::TXL_W-1:0];
        r.byte_offset = pta_pkg::OFS_W'((y * wd + x) * bpt);
        return r;
    endfunction

    function automatic pta_pkg::t_pta_in random_pixel();
        pta_pkg::t_pta_in p;
        logic [pta_pkg::CRD_W-1:0] f[9];
        logic [pta_pkg::CLIP_W-1:0] w[3];
        for (int i = 0; i < 9; i++) begin
            case ($urandom_range(0, 9))
                0: f[i] = '0;
                1: f[i] = 17'h10000;
                2: f[i] = pta_pkg::CRD_W'($urandom);
                default: f[i] = pta_pkg::CRD_W'($urandom_range(0, 65536));
            endcase
        end
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 7))
                0: w[i] = '0;
                1: w[i] = $urandom;
                2: w[i] = $urandom_range(1, 255);
                default: w[i] = $urandom_range(32'h8000, 32'h40_0000);
            endcase
        end
        if ($urandom_range(0, 19) == 0) begin
            f[0] = '0;
            f[1] = '0;
            f[2] = '0;
        end
        p = '{f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], w[0], w[1], w[2]};
        return p;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            adr_ch.ready <= 1'b0;
            rx_idle <= 0;
        end else if (hold_off) begin
            adr_ch.ready <= 1'b0;
        end else if (!quiet_phase && rx_idle > 0) begin
            adr_ch.ready <= 1'b0;
            rx_idle <= rx_idle - 1;
        end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            adr_ch.ready <= 1'b0;
            rx_idle <= $urandom_range(0, 9);
        end else begin
            adr_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        pta_pkg::t_pta_out want;
        if (i_rst_n && adr_ch.valid && adr_ch.ready) begin
            if (texel_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected word: %p", adr_ch.data);
            end else begin
                want = texel_queue.pop_front();
                if (adr_ch.data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, adr_ch.data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (adr_ch.valid && adr_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_MAX) begin
            $display("FAIL perspective_texel_address_core");
            $finish;
        end
    end

    task automatic hold_receiver();
        hold_off = 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    task automatic idle_burst();
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic send_pixel(pta_pkg::t_pta_in p, bit has_known, pta_pkg::t_pta_out known);
        pta_pkg::t_pta_out want;
        idle_burst();
        pix_ch.valid <= 1'b1;
        pix_ch.data <= p;
        want = predict_texel(p);
        if (has_known && want !== known) begin
            mismatches++;
            if (mismatches <= 10) $display("Table row disagrees: %p vs %p", known, want);
        end
        do @(posedge i_clk); while (!pix_ch.ready);
        texel_queue.push_back(want);
    endtask

    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (texel_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [pta_pkg::IDX_W-1:0] idx, logic [pta_pkg::CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.idx <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            pta_pkg::CFG_TEX_WIDTH:  width_reg = val;
            pta_pkg::CFG_TEX_HEIGHT: height_reg = val;
            pta_pkg::CFG_BPT:        bpt_reg = val[pta_pkg::BPT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup(logic [pta_pkg::CFG_W-1:0] w, logic [pta_pkg::CFG_W-1:0] h,
                         logic [pta_pkg::BPT_W-1:0] b);
        drain();
        write_reg(pta_pkg::CFG_TEX_WIDTH, w);
        write_reg(pta_pkg::CFG_TEX_HEIGHT, h);
        write_reg(pta_pkg::CFG_BPT, pta_pkg::CFG_W'(b));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic pta_pkg::t_pta_out texel(int x, int y, int ofs, bit degen);
        pta_pkg::t_pta_out r;
        r.texel_x = pta_pkg::TXL_W'(x);
        r.texel_y = pta_pkg::TXL_W'(y);
        r.byte_offset = pta_pkg::OFS_W'(ofs);
        r.degenerate = degen;
        return r;
    endfunction

    function automatic void add_row(pta_pkg::t_pta_in p, bit k, pta_pkg::t_pta_out r);
        t_row row;
        row.word = p;
        row.has_known = k;
        row.known = r;
        rows.push_back(row);
    endfunction

    function automatic void build_table();
        pta_pkg::t_pta_out none;
        logic [pta_pkg::CRD_W-1:0] one;
        none = '0;
        one = 17'h10000;
        add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1}, 1, texel(0, 0, 0, 1));
        add_row('{one, 0, 0, 0, one, 0, 0, 0, 0, 32'h10000, 1, 1}, 1, texel(0, 0, 0, 0));
        add_row('{one, 0, 0, one, 0, 0, 0, 0, 0, 32'h10000, 1, 1}, 1,
                texel(255, 255, (255 * 256 + 255) * 3, 0));
        add_row('{0, 0, one, 0, 0, 0, 0, one, one, 0, 0, 0}, 0, none);
        add_row('{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
                  17'h1FFFF, 17'h1FFFF, 17'h1FFFF, '1, '1, '1}, 0, none);
        add_row('{17'h8000, 17'h8000, 0, 17'h4000, 17'hC000, one, 0, 0, 0,
                  32'h10000, 32'h40000, 1}, 0, none);
        add_row('{17'h5555, 17'h5555, 17'h5556, 17'h8000, 17'h8000, 17'h8000,
                  17'h8000, 17'h8000, 17'h8000, 32'h20000, 32'h20000, 32'h20000}, 0, none);
        add_row('{17'h0001, 0, 0, 17'h0001, 17'h0001, 0, 0, 0, 0,
                  '1, 32'h10000, 32'h10000}, 0, none);
        add_row('{0, 17'h1AAAA, 17'h15555, 0, 0, 17'h15555, 17'h0AAAA, 17'h0AAAA,
                  17'h15555, 32'hAAAA_5555, 32'h5555_AAAA, 32'h8000_0001}, 0, none);
    endfunction

    initial begin
        pta_pkg::t_pta_out none;
        none = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.idx = pta_pkg::CFG_TEX_WIDTH;
        cfg_ch.data = '0;
        pix_ch.valid = 1'b0;
        pix_ch.data = '0;
        width_reg = pta_pkg::RST_TEX_WIDTH;
        height_reg = pta_pkg::RST_TEX_HEIGHT;
        bpt_reg = pta_pkg::RST_BPT;
        build_table();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_pixel(rows[i].word, rows[i].has_known, rows[i].known);
        setup(13'd4096, 13'd1, pta_pkg::BPT_FOUR);
        for (int i = 0; i < 5; i++) send_pixel(rows[i].word, 0, none);
        setup(13'd0, 13'h1FFF, 3'd0);
        for (int i = 0; i < 5; i++) send_pixel(rows[i].word, 0, none);
        setup(13'd1, 13'd4096, 3'd7);
        for (int i = 0; i < 5; i++) send_pixel(rows[i].word, 0, none);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 0) begin
                setup(pta_pkg::CFG_W'($urandom_range(0, 1) ? $urandom_range(1, 64)
                                                           : $urandom),
                      pta_pkg::CFG_W'($urandom_range(0, 1) ? $urandom_range(1, 64)
                                                           : $urandom),
                      pta_pkg::BPT_W'($urandom_range(0, 7)));
            end
            if (n == 400) begin
                fork
                    hold_receiver();
                join_none
            end
            if (n == 700) drain();
            if (n == N_RANDOM - 200) quiet_phase = 1'b1;
            send_pixel(random_pixel(), 0, none);
        end
        drain();
        if (mismatches == 0) begin
            $display("PASS perspective_texel_address_core");
        end else begin
            $display("FAIL perspective_texel_address_core");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
src/pta_pkg.sv
src/pta_if.sv
src/pta_divider.sv
src/perspective_texel_address_core.sv
test/perspective_texel_address_core_test.sv
